/* design/cas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_pkg
// Shared types and constants for the class-aware box suppression block.
// ----------------------------------------------------------------------------
package cas_pkg;

  localparam int MAX_BOXES = 64;
  localparam int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);
  localparam logic [15:0] THR_RESET = 16'd32768;

  typedef struct packed {
    logic [15:0] x_min;
    logic [15:0] y_min;
    logic [15:0] x_max;
    logic [15:0] y_max;
    logic [15:0] score;
    logic [7:0]  class_id;
    logic        last_box;
  } box_in_t;

  typedef struct packed {
    logic [15:0] kept_x_min;
    logic [15:0] kept_y_min;
    logic [15:0] kept_x_max;
    logic [15:0] kept_y_max;
    logic [15:0] kept_score;
    logic [7:0]  kept_class;
    logic        box_valid;
    logic        overflowed;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic [15:0] x_min;
    logic [15:0] y_min;
    logic [15:0] x_max;
    logic [15:0] y_max;
  } corners_t;

  typedef struct packed {
    corners_t    c;
    logic [15:0] score;
    logic [7:0]  class_id;
  } entry_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] tag;
    corners_t         a;
    corners_t         b;
  } iou_req_t;

  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [IDX_W-1:0] tag;
  } iou_rsp_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_RK_A,
    S_RK_SCAN,
    S_SP_RANK,
    S_SP_BOXA,
    S_SP_CHKA,
    S_SP_SCAN,
    S_EM_RANK,
    S_EM_BOX,
    S_EM_CHK,
    S_EM_END
  } state_t;

endpackage

/* design/cas_iou.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_iou
// Pipelined overlap test: inter * 65536 > thr * union, five stages.
// ----------------------------------------------------------------------------
module cas_iou import cas_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] thr,
  input  iou_req_t    req,
  output iou_rsp_t    rsp,
  output logic        busy
);

  function automatic logic [15:0] span(input logic [15:0] lo, input logic [15:0] hi);
    return (hi > lo) ? (hi - lo) : 16'd0;
  endfunction

  logic             s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [IDX_W-1:0] s1_t_r, s2_t_r, s3_t_r, s4_t_r;
  logic [15:0]      wa_r, ha_r, wb_r, hb_r, iw_r, ih_r;
  logic [31:0]      aa_r, ab_r, ia_r, ia3_r;
  logic [32:0]      uni_r;
  logic [47:0]      lhs_r;
  logic [48:0]      rhs_r;
  iou_rsp_t         rsp_r;

  logic [15:0] lx, ly, hx, hy;
  assign lx = (req.a.x_min > req.b.x_min) ? req.a.x_min : req.b.x_min;
  assign ly = (req.a.y_min > req.b.y_min) ? req.a.y_min : req.b.y_min;
  assign hx = (req.a.x_max < req.b.x_max) ? req.a.x_max : req.b.x_max;
  assign hy = (req.a.y_max < req.b.y_max) ? req.a.y_max : req.b.y_max;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      rsp_r  <= '0;
    end else begin
      s1_v_r    <= req.vld;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      rsp_r.vld <= s4_v_r;
      rsp_r.hit <= {1'b0, lhs_r} > rhs_r;
      rsp_r.tag <= s4_t_r;
    end
    s1_t_r <= req.tag;
    wa_r   <= span(req.a.x_min, req.a.x_max);
    ha_r   <= span(req.a.y_min, req.a.y_max);
    wb_r   <= span(req.b.x_min, req.b.x_max);
    hb_r   <= span(req.b.y_min, req.b.y_max);
    iw_r   <= span(lx, hx);
    ih_r   <= span(ly, hy);
    s2_t_r <= s1_t_r;
    aa_r   <= wa_r * ha_r;
    ab_r   <= wb_r * hb_r;
    ia_r   <= iw_r * ih_r;
    s3_t_r <= s2_t_r;
    uni_r  <= {1'b0, aa_r} + {1'b0, ab_r} - {1'b0, ia_r};
    ia3_r  <= ia_r;
    s4_t_r <= s3_t_r;
    lhs_r  <= {ia3_r, 16'd0};
    rhs_r  <= thr * uni_r;
  end

  assign rsp  = rsp_r;
  assign busy = s1_v_r | s2_v_r | s3_v_r | s4_v_r | rsp_r.vld;

endmodule

/* design/class_aware_box_suppression.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// class_aware_box_suppression
// Stores a frame of boxes, ranks them by score, suppresses overlapping boxes
// of the same class and streams out the survivors in rank order.
// ----------------------------------------------------------------------------
// operation: loading stores one box per start beat; after the last box ranking
//   does one compare a cycle over the box store read port, suppression one pair a
//   cycle through the five-stage overlap pipeline, then emission streams the
//   survivors in rank order
// throughput: one frame at a time; busy is high from the last box until the
//   final result; results cannot be stalled and leave one per strobe
// reset: synchronous, clears the frame, threshold returns to 0.5; no clearing pass
module class_aware_box_suppression import cas_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  box_in_t     in_box,
  output logic        out_valid,
  output result_t     out_res,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]     cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [IDX_W-1:0]     rk_cnt_r, rk_cnt_nxt, pj_r, pj_nxt, a_r, a_nxt, p2_b_r, p2_b_nxt;
  logic                 pv_r, pv_nxt, p1_v_r, p1_v_nxt, p2_v_r, p2_v_nxt;
  logic [MAX_BOXES-1:0] flags_r, flags_nxt;
  entry_t               pend_r, pend_nxt;
  logic                 have_pend_r, have_pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  result_t              out_res_r, out_res_nxt;
  logic [15:0]          thr_r;

  // box store with two read ports, rank store with one
  entry_t           box_mem [MAX_BOXES];
  logic [IDX_W-1:0] rank_mem [MAX_BOXES];
  entry_t           ra_q, rb_q, bw_data;
  logic [IDX_W-1:0] kr_q, kw_data;
  logic             bw_en, ra_en, rb_en, kw_en, kr_en;
  logic [IDX_W-1:0] bw_addr, ra_addr, rb_addr, kw_addr, kr_addr;

  iou_req_t req;
  iou_rsp_t rsp;
  logic     iou_busy;

  logic [IDX_W-1:0] i_idx, j_idx;
  logic i_last, a_alive, rk_done, scan_done;

  assign i_idx     = i_r[IDX_W-1:0];
  assign j_idx     = j_r[IDX_W-1:0];
  assign i_last    = (i_r + CNT_W'(1)) == cnt_r;
  assign a_alive   = !flags_r[a_r] && (ra_q.score != 16'd0);
  assign rk_done   = (j_r == cnt_r) && !pv_r;
  assign scan_done = (j_r == cnt_r) && !p1_v_r && !p2_v_r && !iou_busy;

  function automatic result_t mk_res(input entry_t e, input logic ovf, input logic last);
    result_t r;
    r.kept_x_min  = e.c.x_min;
    r.kept_y_min  = e.c.y_min;
    r.kept_x_max  = e.c.x_max;
    r.kept_y_max  = e.c.y_max;
    r.kept_score  = e.score;
    r.kept_class  = e.class_id;
    r.box_valid   = 1'b1;
    r.overflowed  = ovf;
    r.last_result = last;
    return r;
  endfunction

  cas_iou u_iou (
    .clk   (clk),
    .rst_n (rst_n),
    .thr   (thr_r),
    .req   (req),
    .rsp   (rsp),
    .busy  (iou_busy)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:    if (start && in_box.last_box) state_nxt = S_RK_A;
      S_RK_A:    state_nxt = S_RK_SCAN;
      S_RK_SCAN: if (rk_done) state_nxt = i_last ? S_SP_RANK : S_RK_A;
      S_SP_RANK: state_nxt = S_SP_BOXA;
      S_SP_BOXA: state_nxt = S_SP_CHKA;
      S_SP_CHKA: begin
        if (a_alive && !i_last) state_nxt = S_SP_SCAN;
        else state_nxt = i_last ? S_EM_RANK : S_SP_RANK;
      end
      S_SP_SCAN: if (scan_done) state_nxt = i_last ? S_EM_RANK : S_SP_RANK;
      S_EM_RANK: state_nxt = S_EM_BOX;
      S_EM_BOX:  state_nxt = S_EM_CHK;
      S_EM_CHK:  state_nxt = i_last ? S_EM_END : S_EM_RANK;
      S_EM_END:  state_nxt = S_LOAD;
      default:   state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rk_cnt_nxt    = rk_cnt_r;
    pv_nxt        = 1'b0;
    pj_nxt        = pj_r;
    a_nxt         = a_r;
    p1_v_nxt      = 1'b0;
    p2_v_nxt      = 1'b0;
    p2_b_nxt      = p2_b_r;
    flags_nxt     = flags_r;
    pend_nxt      = pend_r;
    have_pend_nxt = have_pend_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    bw_en = 1'b0; bw_addr = cnt_r[IDX_W-1:0];
    bw_data = '{c: '{in_box.x_min, in_box.y_min, in_box.x_max, in_box.y_max},
                score: in_box.score, class_id: in_box.class_id};
    ra_en = 1'b0; ra_addr = i_idx;
    rb_en = 1'b0; rb_addr = j_idx;
    kw_en = 1'b0; kw_addr = rk_cnt_r; kw_data = i_idx;
    kr_en = 1'b0; kr_addr = i_idx;
    req     = '0;
    req.tag = p2_b_r;
    req.a   = ra_q.c;
    req.b   = rb_q.c;

    case (state_r)
      S_LOAD: begin
        if (start) begin
          if (cnt_r < CNT_W'(MAX_BOXES)) begin
            bw_en   = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      S_RK_A: begin
        ra_en      = 1'b1;
        j_nxt      = '0;
        rk_cnt_nxt = '0;
      end
      S_RK_SCAN: begin
        if (j_r != cnt_r) begin
          rb_en  = 1'b1;
          pv_nxt = 1'b1;
          pj_nxt = j_idx;
          j_nxt  = j_r + CNT_W'(1);
        end
        // rank = boxes ahead: higher score, or equal score that came earlier
        if (pv_r && ((rb_q.score > ra_q.score) ||
                     ((rb_q.score == ra_q.score) && (pj_r < i_idx))))
          rk_cnt_nxt = rk_cnt_r + IDX_W'(1);
        if (rk_done) begin
          kw_en = 1'b1;
          i_nxt = i_last ? '0 : i_r + CNT_W'(1);
        end
      end
      S_SP_RANK, S_EM_RANK: kr_en = 1'b1;
      S_SP_BOXA, S_EM_BOX: begin
        ra_en   = 1'b1;
        ra_addr = kr_q;
        a_nxt   = kr_q;
      end
      S_SP_CHKA: begin
        j_nxt = i_r + CNT_W'(1);
        if (!(a_alive && !i_last)) i_nxt = i_last ? '0 : i_r + CNT_W'(1);
      end
      S_SP_SCAN: begin
        if (j_r != cnt_r) begin
          kr_en    = 1'b1;
          kr_addr  = j_idx;
          p1_v_nxt = 1'b1;
          j_nxt    = j_r + CNT_W'(1);
        end
        p2_v_nxt = p1_v_r;
        if (p1_v_r) begin
          rb_en    = 1'b1;
          rb_addr  = kr_q;
          p2_b_nxt = kr_q;
        end
        req.vld = p2_v_r && (rb_q.class_id == ra_q.class_id);
        if (scan_done) i_nxt = i_last ? '0 : i_r + CNT_W'(1);
      end
      S_EM_CHK: begin
        // hold one survivor back so the final one can carry last_result
        if (a_alive) begin
          if (have_pend_r) begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = mk_res(pend_r, ovf_r, 1'b0);
          end
          pend_nxt      = ra_q;
          have_pend_nxt = 1'b1;
        end
        i_nxt = i_last ? '0 : i_r + CNT_W'(1);
      end
      S_EM_END: begin
        out_valid_nxt = 1'b1;
        if (have_pend_r) begin
          out_res_nxt = mk_res(pend_r, ovf_r, 1'b1);
        end else begin
          out_res_nxt             = '0;
          out_res_nxt.overflowed  = ovf_r;
          out_res_nxt.last_result = 1'b1;
        end
        cnt_nxt       = '0;
        ovf_nxt       = 1'b0;
        flags_nxt     = '0;
        have_pend_nxt = 1'b0;
        i_nxt         = '0;
      end
      default: ;
    endcase

    if (rsp.vld && rsp.hit) flags_nxt[rsp.tag] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (bw_en) box_mem[bw_addr] <= bw_data;
    if (ra_en) ra_q <= box_mem[ra_addr];
    if (rb_en) rb_q <= box_mem[rb_addr];
    if (kw_en) rank_mem[kw_addr] <= kw_data;
    if (kr_en) kr_q <= rank_mem[kr_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      pv_r        <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      flags_r     <= '0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= THR_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      pv_r        <= pv_nxt;
      p1_v_r      <= p1_v_nxt;
      p2_v_r      <= p2_v_nxt;
      flags_r     <= flags_nxt;
      have_pend_r <= have_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) thr_r <= cfg_data;
    end
    rk_cnt_r  <= rk_cnt_nxt;
    pj_r      <= pj_nxt;
    a_r       <= a_nxt;
    p2_b_r    <= p2_b_nxt;
    pend_r    <= pend_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy      = state_r != S_LOAD;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_BOXES))
    else $error("box count beyond capacity");

  a_rsp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.vld |-> state_r == S_SP_SCAN)
    else $error("overlap result outside suppression scan");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.last_result) |-> !busy)
    else $error("final beat while still busy");

  a_frame_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_box.last_box) |=> busy)
    else $error("last box did not start processing");

  a_beat_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_EM_CHK || $past(state_r) == S_EM_END))
    else $error("result beat outside emission");

endmodule
